// ===== sv/bsa_pkg.sv =====
// Shared constants, status and class codes for the bitmap slab allocator.
// Holds the word mask helper used by the allocator core; no dependencies.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int SMALL_SLOTS_DEF  = 288;
    localparam int MEDIUM_SLOTS_DEF = 288;
    localparam int LARGE_SLOTS_DEF  = 288;

    localparam int SMALL_BYTES  = 4;
    localparam int MEDIUM_BYTES = 10;
    localparam int LARGE_BYTES  = 16;

    localparam int ADDR_W   = 24;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 2;
    localparam int SLOT_W   = 9;
    localparam int MAP_W    = 32;

    localparam logic [ADDR_W-1:0] QUERY_SIZE = 24'hFFFFFF;

    // floor(x / 10) as (x * 6554) >> 16, exact for x below 16384
    localparam int MED_RECIP       = 6554;
    localparam int MED_RECIP_W     = 13;
    localparam int MED_RECIP_SHIFT = 16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_SLAB = 3'd5;

    localparam logic [CLASS_W-1:0] CLS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_SMALL  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_MEDIUM = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_LARGE  = 2'd3;

    // Bits of bitmap word w that map to real slots of a class with the given count.
    function automatic logic [MAP_W-1:0] word_mask(int unsigned w, int unsigned slots);
        int unsigned first;
        first = w * MAP_W;
        if (first + MAP_W <= slots)
            return '1;
        else if (first >= slots)
            return '0;
        else
            return (32'd1 << (slots - first)) - 32'd1;
    endfunction

endpackage

// ===== sv/bitmap_slab_allocator_core.sv =====
// Bitmap slab allocator core: three slot classes with free bitmaps in one memory.
// Depends on bsa_pkg for codes, field widths and the word mask helper.
`timescale 1ns / 1ps

// Zero size, oversize, query and null free go from accept via S_DONE to the output.
// Allocate: scans its class and then the larger ones (pipelined reads of the bitmap
// memory, one word a cycle); free: classify, divide, read, write back; classify goes
// straight to done for an address outside the slab. One word in flight; the next
// is taken once the result is registered.
// Reset clears the control state and the per-word valid bits: every slot reads free.
module bitmap_slab_allocator_core #(
    parameter int SMALL_SLOTS  = bsa_pkg::SMALL_SLOTS_DEF,
    parameter int MEDIUM_SLOTS = bsa_pkg::MEDIUM_SLOTS_DEF,
    parameter int LARGE_SLOTS  = bsa_pkg::LARGE_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bsa_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [bsa_pkg::ADDR_W-1:0]    request_size,
    input  logic [bsa_pkg::ADDR_W-1:0]    free_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bsa_pkg::STATUS_W-1:0]  status,
    output logic [bsa_pkg::ADDR_W-1:0]    address,
    output logic [bsa_pkg::CLASS_W-1:0]   size_class,
    output logic [bsa_pkg::SLOT_W-1:0]    slot_index
);
    import bsa_pkg::*;

    localparam int SMALL_WORDS  = (SMALL_SLOTS + MAP_W - 1) / MAP_W;
    localparam int MEDIUM_WORDS = (MEDIUM_SLOTS + MAP_W - 1) / MAP_W;
    localparam int LARGE_WORDS  = (LARGE_SLOTS + MAP_W - 1) / MAP_W;
    localparam int TOTAL_WORDS  = SMALL_WORDS + MEDIUM_WORDS + LARGE_WORDS;
    localparam int MAX_WORDS_SM = (SMALL_WORDS > MEDIUM_WORDS) ? SMALL_WORDS : MEDIUM_WORDS;
    localparam int MAX_WORDS    = (MAX_WORDS_SM > LARGE_WORDS) ? MAX_WORDS_SM : LARGE_WORDS;
    localparam int WORD_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int MEM_AW       = $clog2(TOTAL_WORDS);
    localparam int IDX_W        = (WORD_W + 5 > SLOT_W) ? WORD_W + 5 : SLOT_W;

    localparam int SMALL_END    = SMALL_SLOTS * SMALL_BYTES;
    localparam int MEDIUM_END   = SMALL_END + MEDIUM_SLOTS * MEDIUM_BYTES;
    localparam int LARGE_END    = MEDIUM_END + LARGE_SLOTS * LARGE_BYTES;
    localparam int SMALL_REG    = SMALL_SLOTS * SMALL_BYTES;
    localparam int MEDIUM_REG   = MEDIUM_SLOTS * MEDIUM_BYTES;
    localparam int LARGE_REG    = LARGE_SLOTS * LARGE_BYTES;
    localparam int REG_MAX_SM   = (SMALL_REG > MEDIUM_REG) ? SMALL_REG : MEDIUM_REG;
    localparam int REG_MAX      = (REG_MAX_SM > LARGE_REG) ? REG_MAX_SM : LARGE_REG;
    localparam int LOC_W        = $clog2(REG_MAX);
    localparam int PROD_W       = LOC_W + MED_RECIP_W;

    localparam logic [ADDR_W-1:0] SMALL_END_A  = ADDR_W'(SMALL_END);
    localparam logic [ADDR_W-1:0] MEDIUM_END_A = ADDR_W'(MEDIUM_END);
    localparam logic [ADDR_W-1:0] LARGE_END_A  = ADDR_W'(LARGE_END);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CLASSIFY = 7'b0000010,
        S_DIVIDE   = 7'b0000100,
        S_FREE_RD  = 7'b0001000,
        S_FREE_WR  = 7'b0010000,
        S_SCAN     = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    function automatic int class_slots(logic [CLASS_W-1:0] cls);
        unique case (cls)
            CLS_SMALL:  return SMALL_SLOTS;
            CLS_MEDIUM: return MEDIUM_SLOTS;
            default:    return LARGE_SLOTS;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] class_last(logic [CLASS_W-1:0] cls);
        unique case (cls)
            CLS_SMALL:  return WORD_W'(SMALL_WORDS - 1);
            CLS_MEDIUM: return WORD_W'(MEDIUM_WORDS - 1);
            default:    return WORD_W'(LARGE_WORDS - 1);
        endcase
    endfunction

    function automatic logic [MEM_AW-1:0] map_addr(logic [CLASS_W-1:0] cls,
                                                    logic [WORD_W-1:0] w);
        logic [MEM_AW-1:0] base;
        unique case (cls)
            CLS_SMALL:  base = '0;
            CLS_MEDIUM: base = MEM_AW'(SMALL_WORDS);
            default:    base = MEM_AW'(SMALL_WORDS + MEDIUM_WORDS);
        endcase
        return base + MEM_AW'(w);
    endfunction

    // Bitmap memory and its per-word valid bits
    logic [MAP_W-1:0]       map_mem [0:TOTAL_WORDS-1];
    logic [TOTAL_WORDS-1:0] map_valid_reg;
    logic [MAP_W-1:0]       rd_data_reg;
    logic                   rd_valid_reg;
    logic                   rd_en;
    logic [MEM_AW-1:0]      rd_addr;
    logic                   wr_en;
    logic [MEM_AW-1:0]      wr_addr;
    logic [MAP_W-1:0]       wr_data;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      region_base_reg;
    logic [ADDR_W-1:0]      faddr_reg, faddr_next;
    logic [CLASS_W-1:0]     cls_reg, cls_next;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic                   scan_end_reg, scan_end_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [CLASS_W-1:0]     chk_cls_reg, chk_cls_next;
    logic [WORD_W-1:0]      chk_word_reg, chk_word_next;
    logic [LOC_W-1:0]       loc_reg, loc_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [CLASS_W-1:0]     res_cls_reg, res_cls_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [ADDR_W-1:0]      out_addr_reg, out_addr_next;
    logic [CLASS_W-1:0]     out_cls_reg, out_cls_next;
    logic [IDX_W-1:0]       out_idx_reg, out_idx_next;

    logic [CLASS_W-1:0]     mask_cls;
    logic [WORD_W-1:0]      mask_word;
    logic [MAP_W-1:0]       cur_mask;
    logic [MAP_W-1:0]       cur_word;
    logic [4:0]             low_bit;
    logic [IDX_W-1:0]       found_idx;
    logic [ADDR_W-1:0]      found_scaled;
    logic [ADDR_W-1:0]      found_start;
    logic [ADDR_W-1:0]      offset;
    logic [PROD_W-1:0]      med_prod;
    logic [WORD_W-1:0]      free_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                map_valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= map_valid_reg[rd_addr];
        end
    end

    assign free_word = WORD_W'(idx_reg >> 5);

    // Word under test: the free path looks at its own word, the scan at the checked one
    always_comb
    begin
        if (state_reg == S_FREE_WR)
        begin
            mask_cls  = cls_reg;
            mask_word = free_word;
        end
        else
        begin
            mask_cls  = chk_cls_reg;
            mask_word = chk_word_reg;
        end
        cur_mask = word_mask(int'(mask_word), class_slots(mask_cls));
        cur_word = (rd_valid_reg ? rd_data_reg : cur_mask) & cur_mask;
    end

    always_comb
    begin
        low_bit = '0;
        for (int b = MAP_W - 1; b >= 0; b--)
        begin
            if (cur_word[b])
                low_bit = 5'(b);
        end
    end

    assign found_idx = IDX_W'({chk_word_reg, low_bit});

    always_comb
    begin
        unique case (chk_cls_reg)
            CLS_SMALL:
            begin
                found_start  = '0;
                found_scaled = ADDR_W'(found_idx) << 2;
            end
            CLS_MEDIUM:
            begin
                found_start  = SMALL_END_A;
                found_scaled = (ADDR_W'(found_idx) << 3) + (ADDR_W'(found_idx) << 1);
            end
            default:
            begin
                found_start  = MEDIUM_END_A;
                found_scaled = ADDR_W'(found_idx) << 4;
            end
        endcase
    end

    assign offset   = faddr_reg - region_base_reg;
    assign med_prod = PROD_W'(loc_reg) * PROD_W'(MED_RECIP);

    always_comb
    begin
        state_next      = state_reg;
        faddr_next      = faddr_reg;
        cls_next        = cls_reg;
        word_next       = word_reg;
        scan_end_next   = scan_end_reg;
        chk_valid_next  = chk_valid_reg;
        chk_cls_next    = chk_cls_reg;
        chk_word_next   = chk_word_reg;
        loc_next        = loc_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_cls_next    = res_cls_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_cls_next    = out_cls_reg;
        out_idx_next    = out_idx_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next = '0;
                    res_cls_next  = CLS_NONE;
                    res_idx_next  = '0;
                    if (action == ACT_ALLOC)
                    begin
                        if (request_size == '0)
                        begin
                            res_status_next = ST_NULL;
                            state_next      = S_DONE;
                        end
                        else if (request_size == QUERY_SIZE ||
                                 request_size > ADDR_W'(LARGE_BYTES))
                        begin
                            res_status_next = ST_TOO_BIG;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            if (request_size <= ADDR_W'(SMALL_BYTES))
                                cls_next = CLS_SMALL;
                            else if (request_size <= ADDR_W'(MEDIUM_BYTES))
                                cls_next = CLS_MEDIUM;
                            else
                                cls_next = CLS_LARGE;
                            word_next      = '0;
                            scan_end_next  = 1'b0;
                            chk_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_address == '0)
                        begin
                            res_status_next = ST_NULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            faddr_next = free_address;
                            state_next = S_CLASSIFY;
                        end
                    end
                end
            end

            S_CLASSIFY:
            begin
                if (offset < SMALL_END_A)
                begin
                    cls_next   = CLS_SMALL;
                    loc_next   = LOC_W'(offset);
                    state_next = S_DIVIDE;
                end
                else if (offset < MEDIUM_END_A)
                begin
                    cls_next   = CLS_MEDIUM;
                    loc_next   = LOC_W'(offset - SMALL_END_A);
                    state_next = S_DIVIDE;
                end
                else if (offset < LARGE_END_A)
                begin
                    cls_next   = CLS_LARGE;
                    loc_next   = LOC_W'(offset - MEDIUM_END_A);
                    state_next = S_DIVIDE;
                end
                else
                begin
                    res_status_next = ST_NOT_SLAB;
                    state_next      = S_DONE;
                end
            end

            S_DIVIDE:
            begin
                unique case (cls_reg)
                    CLS_SMALL:  idx_next = IDX_W'(loc_reg >> 2);
                    CLS_MEDIUM: idx_next = IDX_W'(med_prod >> MED_RECIP_SHIFT);
                    default:    idx_next = IDX_W'(loc_reg >> 4);
                endcase
                state_next = S_FREE_RD;
            end

            S_FREE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = map_addr(cls_reg, free_word);
                state_next = S_FREE_WR;
            end

            S_FREE_WR:
            begin
                wr_en           = 1'b1;
                wr_addr         = map_addr(cls_reg, free_word);
                wr_data         = cur_word | (32'd1 << idx_reg[4:0]);
                res_status_next = ST_FREED;
                res_cls_next    = cls_reg;
                res_idx_next    = idx_reg;
                state_next      = S_DONE;
            end

            S_SCAN:
            begin
                if (chk_valid_reg && cur_word != '0)
                begin
                    // claim the lowest free slot and stop issuing reads
                    wr_en           = 1'b1;
                    wr_addr         = map_addr(chk_cls_reg, chk_word_reg);
                    wr_data         = cur_word & ~(32'd1 << low_bit);
                    res_status_next = ST_GRANTED;
                    res_cls_next    = chk_cls_reg;
                    res_idx_next    = found_idx;
                    res_addr_next   = region_base_reg + found_start + found_scaled;
                    chk_valid_next  = 1'b0;
                    state_next      = S_DONE;
                end
                else if (!scan_end_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = map_addr(cls_reg, word_reg);
                    chk_valid_next = 1'b1;
                    chk_cls_next   = cls_reg;
                    chk_word_next  = word_reg;
                    if (word_reg == class_last(cls_reg))
                    begin
                        // spill into the next larger class
                        if (cls_reg == CLS_LARGE)
                            scan_end_next = 1'b1;
                        else
                        begin
                            cls_next  = cls_reg + 2'd1;
                            word_next = '0;
                        end
                    end
                    else
                        word_next = word_reg + 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_cls_next    = res_cls_reg;
                    out_idx_next    = res_idx_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            region_base_reg <= '0;
            scan_end_reg    <= 1'b0;
            chk_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_end_reg  <= scan_end_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                region_base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        faddr_reg      <= faddr_next;
        cls_reg        <= cls_next;
        word_reg       <= word_next;
        chk_cls_reg    <= chk_cls_next;
        chk_word_reg   <= chk_word_next;
        loc_reg        <= loc_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_cls_reg    <= res_cls_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_cls_reg    <= out_cls_next;
        out_idx_reg    <= out_idx_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign address    = out_addr_reg;
    assign size_class = out_cls_reg;
    assign slot_index = out_idx_reg[SLOT_W-1:0];

endmodule

// ===== dv/bitmap_slab_allocator_core_tb.sv =====
// Self-checking bench for bitmap_slab_allocator_core: a queue-fed driver, a result monitor
// and an allocator predictor that tracks every slot of the three classes.
// Depends on bsa_pkg and the core RTL only.
`timescale 1ns / 1ps

module bitmap_slab_allocator_core_tb;

    import bsa_pkg::*;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } slab_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   address;
        logic [CLASS_W-1:0]  cls;
        logic [SLOT_W-1:0]   slot;
    } slab_reply_t;

    typedef struct packed {
        int unsigned bytes;
        int unsigned start;
        int unsigned slots;
    } class_geom_t;

    localparam int MAX_SLOTS = (SMALL_SLOTS_DEF > MEDIUM_SLOTS_DEF) ?
        ((SMALL_SLOTS_DEF > LARGE_SLOTS_DEF) ? SMALL_SLOTS_DEF : LARGE_SLOTS_DEF) :
        ((MEDIUM_SLOTS_DEF > LARGE_SLOTS_DEF) ? MEDIUM_SLOTS_DEF : LARGE_SLOTS_DEF);
    localparam int unsigned LARGE_START = SMALL_SLOTS_DEF * SMALL_BYTES
                                        + MEDIUM_SLOTS_DEF * MEDIUM_BYTES;
    localparam int unsigned SLAB_END    = LARGE_START + LARGE_SLOTS_DEF * LARGE_BYTES;
    localparam int          DRAIN_CYCLES = 40;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [ADDR_W-1:0]   cfg_wr_data  = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic                action       = ACT_ALLOC;
    logic [ADDR_W-1:0]   request_size = '0;
    logic [ADDR_W-1:0]   free_address = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
    logic [CLASS_W-1:0]  size_class;
    logic [SLOT_W-1:0]   slot_index;

    // predictor state: one flag per slot, set while the slot is free
    bit                slot_free [CLS_SMALL:CLS_LARGE][0:MAX_SLOTS-1];
    logic [ADDR_W-1:0] model_base;

    slab_op_t    queued_ops[$];
    slab_reply_t pending_replies[$];
    int unsigned ops_queued  = 0;
    int unsigned ops_taken   = 0;
    int unsigned bad_replies = 0;

    int unsigned send_gap        = 0;
    int unsigned recv_stall_left = 0;
    int unsigned tick            = 0;
    int unsigned hold_left       = 0;
    logic        hold_off        = 1'b0;
    logic        calm            = 1'b0;

    bitmap_slab_allocator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .request_size (request_size),
        .free_address (free_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .address      (address),
        .size_class   (size_class),
        .slot_index   (slot_index)
    );

    always #10 clk = ~clk;

    function automatic class_geom_t geom_of(int c);
        class_geom_t g;
        case (c)
            CLS_SMALL:  g = '{SMALL_BYTES, 0, SMALL_SLOTS_DEF};
            CLS_MEDIUM: g = '{MEDIUM_BYTES, SMALL_SLOTS_DEF * SMALL_BYTES, MEDIUM_SLOTS_DEF};
            default:    g = '{LARGE_BYTES, LARGE_START, LARGE_SLOTS_DEF};
        endcase
        return g;
    endfunction

    // Update the slot flags for one request and return the reply it earns.
    function automatic slab_reply_t apply_slab_op(logic act, logic [ADDR_W-1:0] size,
                                                  logic [ADDR_W-1:0] faddr);
        slab_reply_t res;
        class_geom_t g;
        logic [ADDR_W-1:0] off;
        int first;
        int idx;
        res = '0;
        if (act == ACT_ALLOC)
        begin
            if (size == '0)
                res.status = ST_NULL;
            else if (size == QUERY_SIZE || size > LARGE_BYTES)
                res.status = ST_TOO_BIG;
            else
            begin
                first = (size <= SMALL_BYTES) ? CLS_SMALL :
                        (size <= MEDIUM_BYTES) ? CLS_MEDIUM : CLS_LARGE;
                res.status = ST_FULL;
                // spill upward until some class has a free slot
                for (int c = first; c <= CLS_LARGE && res.status == ST_FULL; c++)
                begin
                    g = geom_of(c);
                    idx = -1;
                    for (int s = 0; s < g.slots && idx < 0; s++)
                        if (slot_free[c][s])
                            idx = s;
                    if (idx >= 0)
                    begin
                        slot_free[c][idx] = 1'b0;
                        res.status  = ST_GRANTED;
                        res.cls     = CLASS_W'(c);
                        res.slot    = SLOT_W'(idx);
                        res.address = model_base + ADDR_W'(g.start + idx * g.bytes);
                    end
                end
            end
        end
        else
        begin
            off = faddr - model_base;
            if (faddr == '0)
                res.status = ST_NULL;
            else
            begin
                res.status = ST_NOT_SLAB;
                for (int c = CLS_SMALL; c <= CLS_LARGE && res.status == ST_NOT_SLAB; c++)
                begin
                    g = geom_of(c);
                    if (off < g.start + g.slots * g.bytes)
                    begin
                        idx = (off - g.start) / g.bytes;
                        slot_free[c][idx] = 1'b1;
                        res.status = ST_FREED;
                        res.cls    = CLASS_W'(c);
                        res.slot   = SLOT_W'(idx);
                    end
                end
            end
        end
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(40, 12);
    endfunction

    task automatic push_op(logic act, logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] faddr);
        queued_ops.push_back('{act, size, faddr});
        ops_queued++;
    endtask

    // Allocations of plausible sizes and frees that land on real slots, with some noise.
    task automatic queue_phase(int unsigned count, int unsigned alloc_pct,
                               logic [ADDR_W-1:0] base);
        slab_op_t op;
        class_geom_t g;
        int unsigned r;
        int c;
        repeat (count)
        begin
            op.request_size = ADDR_W'($urandom);
            op.free_address = ADDR_W'($urandom);
            r = $urandom_range(99);
            if (r < 8)
                op.action = 1'($urandom);
            else if ($urandom_range(99) < alloc_pct)
            begin
                op.action = ACT_ALLOC;
                r = $urandom_range(99);
                if (r < 3)
                    op.request_size = '0;
                else if (r < 5)
                    op.request_size = QUERY_SIZE;
                else if (r < 9)
                    op.request_size = ADDR_W'($urandom_range(40, LARGE_BYTES + 1));
                else
                    op.request_size = ADDR_W'($urandom_range(LARGE_BYTES, 1));
            end
            else
            begin
                op.action = ACT_FREE;
                r = $urandom_range(99);
                if (r < 5)
                    op.free_address = base + ADDR_W'(SLAB_END + $urandom_range(15));
                else if (r < 10)
                    op.free_address = base - ADDR_W'(1 + $urandom_range(15));
                else
                begin
                    c = $urandom_range(CLS_LARGE, CLS_SMALL);
                    g = geom_of(c);
                    op.free_address = base + ADDR_W'(g.start
                        + $urandom_range(g.slots - 1) * g.bytes + $urandom_range(g.bytes - 1));
                end
            end
            push_op(op.action, op.request_size, op.free_address);
        end
    endtask

    // Wait until every queued word has been answered, then write the base register.
    task automatic write_base(logic [ADDR_W-1:0] base);
        while (ops_taken != ops_queued || pending_replies.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge clk);
        model_base = base;
        cfg_wr_en <= 1'b0;
    endtask

    // driver
    always @(posedge clk)
    begin
        slab_op_t op;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_replies.push_back(apply_slab_op(action, request_size, free_address));
                ops_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (queued_ops.size() != 0)
                begin
                    op = queued_ops.pop_front();
                    action       <= op.action;
                    request_size <= op.request_size;
                    free_address <= op.free_address;
                    in_valid     <= 1'b1;
                    send_gap     <= calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        slab_reply_t want;
        int unsigned n;
        if (!rst_n)
        begin
            out_stall       <= 1'b0;
            recv_stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    bad_replies++;
                    if (bad_replies <= 10)
                        $display("%0t: unexpected word: status %0d address %h class %0d slot %0d",
                                 $realtime, status, address, size_class, slot_index);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status || address !== want.address ||
                        size_class !== want.cls || slot_index !== want.slot)
                    begin
                        bad_replies++;
                        // fields in order: status, address, class, slot
                        if (bad_replies <= 10)
                            $display("%0t: expected %0d %h %0d %0d, got %0d %h %0d %0d",
                                     $realtime, want.status, want.address, want.cls, want.slot,
                                     status, address, size_class, slot_index);
                    end
                end
            end
            if (recv_stall_left != 0)
            begin
                recv_stall_left <= recv_stall_left - 1;
                out_stall       <= 1'b1;
            end
            else if (calm)
                out_stall <= hold_off;
            else
            begin
                n = pick_gap();
                if (n != 0)
                begin
                    recv_stall_left <= n - 1;
                    out_stall       <= 1'b1;
                end
                else
                    out_stall <= hold_off;
            end
        end
    end

    // long receiver hold-offs and stretches with no idling on either side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick      <= 0;
            hold_left <= 0;
            hold_off  <= 1'b0;
            calm      <= 1'b0;
        end
        else
        begin
            tick <= tick + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                hold_off  <= (hold_left > 1);
            end
            else if (tick % 3000 == 1500)
            begin
                hold_left <= $urandom_range(400, 200);
                hold_off  <= 1'b1;
            end
            if (tick % 700 == 0)
                calm <= ($urandom_range(3) == 0);
        end
    end

    initial
    begin
        #20_000_000;
        $display("bitmap_slab_allocator_core verification failed");
        $finish;
    end

    initial
    begin
        model_base = '0;
        foreach (slot_free[c, s])
            slot_free[c][s] = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // base 0 after reset: codes, class picks and free corner cases
        push_op(ACT_ALLOC, '0, ADDR_W'($urandom));
        push_op(ACT_ALLOC, QUERY_SIZE, ADDR_W'($urandom));
        push_op(ACT_ALLOC, ADDR_W'(LARGE_BYTES + 1), '0);
        push_op(ACT_ALLOC, 24'h800000, 24'hFFFFFF);
        push_op(ACT_ALLOC, 24'd1, '0);
        push_op(ACT_ALLOC, ADDR_W'(SMALL_BYTES), '0);
        push_op(ACT_ALLOC, ADDR_W'(SMALL_BYTES + 1), '0);
        push_op(ACT_ALLOC, ADDR_W'(MEDIUM_BYTES), '0);
        push_op(ACT_ALLOC, ADDR_W'(MEDIUM_BYTES + 1), '0);
        push_op(ACT_ALLOC, ADDR_W'(LARGE_BYTES), '0);
        // null free even though the first small slot sits at address zero
        push_op(ACT_FREE, ADDR_W'($urandom), '0);
        push_op(ACT_FREE, '0, ADDR_W'(SMALL_BYTES + 2));
        push_op(ACT_FREE, '0, ADDR_W'(SMALL_BYTES + 2));
        push_op(ACT_FREE, '0, ADDR_W'(SMALL_SLOTS_DEF * SMALL_BYTES + MEDIUM_BYTES - 1));
        push_op(ACT_FREE, '0, ADDR_W'(LARGE_START));
        push_op(ACT_FREE, '0, ADDR_W'(SLAB_END - 1));
        push_op(ACT_FREE, '0, ADDR_W'(SLAB_END));
        push_op(ACT_FREE, '0, 24'hFFFFFF);
        push_op(ACT_ALLOC, 24'd3, '0);

        write_base(24'hFFFFFF);
        queue_phase(250, 85, 24'hFFFFFF);
        write_base(ADDR_W'($urandom));
        queue_phase(700, 97, model_base);
        // region wraps through address zero
        write_base(24'hFFF000);
        queue_phase(300, 60, 24'hFFF000);
        write_base('0);
        queue_phase(530, 25, '0);

        while (ops_taken != ops_queued || pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_replies == 0)
            $display("bitmap_slab_allocator_core verification clean");
        else
            $display("bitmap_slab_allocator_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bsa_pkg.sv
sv/bitmap_slab_allocator_core.sv
dv/bitmap_slab_allocator_core_tb.sv
